// ===== hdl/ptom_pkg.sv =====
// Shared types and constants for the price-time order matcher.
// Used by ptom_scan and price_time_order_matcher_core; depends on nothing.
package ptom_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = 6;
    localparam int LEVELS  = 256;
    localparam int PRICE_W = 8;
    localparam int LEV_W   = 9;
    localparam int QTY_W   = 16;
    localparam int SEQ_W   = 32;
    localparam logic [SLOT_W-1:0] MAX_TRADES = SLOT_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        MODE_SUBMIT = 2'd0,
        MODE_CANCEL = 2'd1,
        MODE_MODIFY = 2'd2,
        MODE_BAD    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_TRADE       = 3'd0,
        ST_RESTED      = 3'd1,
        ST_FILLED      = 3'd2,
        ST_INVALID     = 3'd3,
        ST_FULL        = 3'd4,
        ST_CANCELLED   = 3'd5,
        ST_CANCEL_FAIL = 3'd6,
        ST_MODIFY_FAIL = 3'd7
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_HREAD,
        S_UL_LEV,
        S_UL_WALK,
        S_UL_DONE,
        S_SETTLE,
        S_M_BEST,
        S_M_LEV,
        S_M_SLOT,
        S_M_END,
        S_A_LEV,
        S_A_TAIL,
        S_O_BEST,
        S_O_RD,
        S_O_LOAD,
        S_O_HOLD
    } state_t;

    typedef struct packed {
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   rem;
        logic               touched;
        logic [SLOT_W-1:0]  nxt;
    } slot_t;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } level_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  rh;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } trade_t;

    typedef struct packed {
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic               free_found;
        logic [SLOT_W-1:0]  free_idx;
    } scan_t;

endpackage

// ===== hdl/ptom_scan.sv =====
// Registered two-level search for the best bid, best ask and lowest free slot.
// Depends on ptom_pkg; results follow the inputs by one register stage.
module ptom_scan (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [2*ptom_pkg::LEVELS-1:0]     level_bits,
    input  logic [ptom_pkg::SLOTS-1:0]        used,
    output ptom_pkg::scan_t                   res
);

    logic [ptom_pkg::LEVELS-1:0] bid_bits;
    logic [ptom_pkg::LEVELS-1:0] ask_bits;
    logic [ptom_pkg::SLOTS-1:0]  free_bits;
    logic [15:0] bid_g;
    logic [15:0] ask_g;
    logic [7:0]  free_g;
    logic [3:0]  bid_grp_next;
    logic [3:0]  ask_grp_next;
    logic [2:0]  free_grp_next;
    logic [3:0]  bid_grp_reg;
    logic [3:0]  ask_grp_reg;
    logic [2:0]  free_grp_reg;
    logic [15:0] bid_sel_reg;
    logic [15:0] ask_sel_reg;
    logic [7:0]  free_sel_reg;
    logic [3:0]  bid_idx;
    logic [3:0]  ask_idx;
    logic [2:0]  free_idx;

    always_comb
    begin
        bid_bits  = level_bits[ptom_pkg::LEVELS-1:0] & ~ptom_pkg::LEVELS'(1);
        ask_bits  = level_bits[2*ptom_pkg::LEVELS-1:ptom_pkg::LEVELS] & ~ptom_pkg::LEVELS'(1);
        free_bits = ~used;
        for (int g = 0; g < 16; g++)
        begin
            bid_g[g] = |bid_bits[g*16 +: 16];
            ask_g[g] = |ask_bits[g*16 +: 16];
        end
        for (int g = 0; g < 8; g++)
        begin
            free_g[g] = |free_bits[g*8 +: 8];
        end
        bid_grp_next = '0;
        for (int g = 0; g < 16; g++)
        begin
            if (bid_g[g])
            begin
                bid_grp_next = 4'(g);
            end
        end
        ask_grp_next = '0;
        for (int g = 15; g >= 0; g--)
        begin
            if (ask_g[g])
            begin
                ask_grp_next = 4'(g);
            end
        end
        free_grp_next = '0;
        for (int g = 7; g >= 0; g--)
        begin
            if (free_g[g])
            begin
                free_grp_next = 3'(g);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_grp_reg  <= '0;
            ask_grp_reg  <= '0;
            free_grp_reg <= '0;
            bid_sel_reg  <= '0;
            ask_sel_reg  <= '0;
            free_sel_reg <= '1;
        end
        else
        begin
            bid_grp_reg  <= bid_grp_next;
            ask_grp_reg  <= ask_grp_next;
            free_grp_reg <= free_grp_next;
            bid_sel_reg  <= bid_bits[{bid_grp_next, 4'b0000} +: 16];
            ask_sel_reg  <= ask_bits[{ask_grp_next, 4'b0000} +: 16];
            free_sel_reg <= free_bits[{free_grp_next, 3'b000} +: 8];
        end
    end

    always_comb
    begin
        bid_idx = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (bid_sel_reg[i])
            begin
                bid_idx = 4'(i);
            end
        end
        ask_idx = '0;
        for (int i = 15; i >= 0; i--)
        begin
            if (ask_sel_reg[i])
            begin
                ask_idx = 4'(i);
            end
        end
        free_idx = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (free_sel_reg[i])
            begin
                free_idx = 3'(i);
            end
        end
        res.bid        = (|bid_sel_reg) ? {bid_grp_reg, bid_idx} : '0;
        res.ask        = (|ask_sel_reg) ? {ask_grp_reg, ask_idx} : '0;
        res.free_found = |free_sel_reg;
        res.free_idx   = {free_grp_reg, free_idx};
    end

endmodule

// ===== hdl/price_time_order_matcher_core.sv =====
// Top level of the price-time order matcher: sequencer, slot and level memories.
// Depends on ptom_pkg and ptom_scan.
//
// Usage: one order command enters as a word on the s_axis channel (tuser holds
// the mode). The block then works on that command alone and holds s_axis_tready
// low until every result word of it has been taken on the m_axis channel.
// Results are zero or more trade words followed by one closing word with tlast
// set; tuser holds the status of each word. All words of a command carry the
// sequence number and best prices as they stand after the command.
// Before the first result word: an invalid word or a full book goes from dispatch
// straight to the output, a failed cancel or modify also reads the handle, a cancel
// walks the level from its head to the order, and a submit that rests also adds
// itself to its level (a tail update at an occupied one). Each trade goes through
// best-price search, level read, slot read and update, and a settle state.
// Each trade word is read, loaded and held; the closing word is read and held.
// Reset clears the book, the slot map and the sequence count at once; no
// sweep is needed. When the receiver stalls, the result word holds and the
// block waits; no word is dropped.
module price_time_order_matcher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // side[0], price[8:1], quantity[24:9], order_handle[30:25], zero pad[31]
    input  logic [31:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // order_handle_out[5:0], sequence_number[37:6], resting_handle[43:38],
    // trade_price[51:44], trade_quantity[67:52], best_bid[75:68],
    // best_ask[83:76], zero pad[87:84]
    output logic [87:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    ptom_pkg::state_t state_reg, state_next;
    ptom_pkg::state_t ret_reg, ret_next;

    ptom_pkg::mode_t  mode_reg, mode_next;
    logic                              side_reg, side_next;
    logic [ptom_pkg::PRICE_W-1:0]      price_reg, price_next;
    logic [ptom_pkg::QTY_W-1:0]        qty_reg, qty_next;
    logic [ptom_pkg::SLOT_W-1:0]       hnd_reg, hnd_next;
    logic [ptom_pkg::SLOT_W-1:0]       s_reg, s_next;
    logic [ptom_pkg::QTY_W-1:0]        rem_reg, rem_next;
    logic [ptom_pkg::SEQ_W-1:0]        cnt_reg, cnt_next;
    logic [ptom_pkg::SLOT_W-1:0]       tcnt_reg, tcnt_next;
    logic [ptom_pkg::SLOT_W-1:0]       kidx_reg, kidx_next;
    ptom_pkg::status_t                 close_reg, close_next;
    logic [ptom_pkg::SLOT_W-1:0]       hout_reg, hout_next;
    logic [ptom_pkg::PRICE_W-1:0]      bp_reg, bp_next;
    logic [ptom_pkg::LEV_W-1:0]        lv_reg, lv_next;
    logic [ptom_pkg::SLOT_W-1:0]       head_reg, head_next;
    logic [ptom_pkg::SLOT_W-1:0]       tail_reg, tail_next;
    logic [ptom_pkg::SLOT_W-1:0]       cur_reg, cur_next;
    logic [ptom_pkg::SLOT_W-1:0]       hnext_reg, hnext_next;
    logic [ptom_pkg::PRICE_W-1:0]      bb_reg, bb_next;
    logic [ptom_pkg::PRICE_W-1:0]      ba_reg, ba_next;
    ptom_pkg::status_t                 ostat_reg, ostat_next;
    logic [ptom_pkg::SLOT_W-1:0]       ohand_reg, ohand_next;
    logic [ptom_pkg::SLOT_W-1:0]       orh_reg, orh_next;
    logic [ptom_pkg::PRICE_W-1:0]      otp_reg, otp_next;
    logic [ptom_pkg::QTY_W-1:0]        otq_reg, otq_next;
    logic                              olast_reg, olast_next;

    logic [ptom_pkg::SLOTS-1:0]        used_reg;
    logic [2*ptom_pkg::LEVELS-1:0]     nz_reg;

    ptom_pkg::slot_t  slot_mem [ptom_pkg::SLOTS];
    ptom_pkg::level_t level_mem [2*ptom_pkg::LEVELS];
    ptom_pkg::trade_t tbuf_mem [ptom_pkg::SLOTS];

    ptom_pkg::slot_t                   slot_rdata_reg, slot_wdata;
    logic [ptom_pkg::SLOT_W-1:0]       slot_raddr, slot_waddr;
    logic                              slot_we;
    ptom_pkg::level_t                  level_rdata_reg, level_wdata;
    logic [ptom_pkg::LEV_W-1:0]        level_raddr;
    logic                              level_we;
    ptom_pkg::trade_t                  tbuf_rdata_reg, tbuf_wdata;
    logic                              tbuf_we;

    logic                              used_we, used_wval;
    logic [ptom_pkg::SLOT_W-1:0]       used_waddr;
    logic                              nz_we, nz_wval;

    ptom_pkg::scan_t                   scan;
    logic                              vals_ok;
    logic [ptom_pkg::PRICE_W-1:0]      opp_bp;
    logic                              crosses;
    logic [ptom_pkg::QTY_W-1:0]        tq;
    logic [ptom_pkg::QTY_W-1:0]        new_rem;
    logic                              accept;

    ptom_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .level_bits (nz_reg),
        .used       (used_reg),
        .res        (scan)
    );

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign vals_ok = (price_reg != '0) && (qty_reg != '0);
    assign opp_bp  = side_reg ? scan.bid : scan.ask;
    assign crosses = side_reg ? (opp_bp >= price_reg) : (opp_bp <= price_reg);
    assign tq      = (rem_reg < slot_rdata_reg.rem) ? rem_reg : slot_rdata_reg.rem;
    assign new_rem = slot_rdata_reg.rem - tq;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ptom_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ptom_pkg::S_DISPATCH;
                end
            end
            ptom_pkg::S_DISPATCH:
            begin
                state_next = ptom_pkg::S_SETTLE;
                ret_next   = ptom_pkg::S_O_BEST;
                if ((mode_reg == ptom_pkg::MODE_CANCEL) || (mode_reg == ptom_pkg::MODE_MODIFY))
                begin
                    state_next = ptom_pkg::S_HREAD;
                end
                else if ((mode_reg == ptom_pkg::MODE_SUBMIT) && vals_ok && scan.free_found)
                begin
                    state_next = ptom_pkg::S_M_BEST;
                end
            end
            ptom_pkg::S_HREAD:
            begin
                if (!used_reg[hnd_reg] || ((mode_reg == ptom_pkg::MODE_MODIFY)
                    && (slot_rdata_reg.touched || !vals_ok)))
                begin
                    state_next = ptom_pkg::S_SETTLE;
                    ret_next   = ptom_pkg::S_O_BEST;
                end
                else
                begin
                    state_next = ptom_pkg::S_UL_LEV;
                end
            end
            ptom_pkg::S_UL_LEV:
            begin
                if (!nz_reg[lv_reg] || (level_rdata_reg.head == hnd_reg))
                begin
                    state_next = ptom_pkg::S_UL_DONE;
                end
                else
                begin
                    state_next = ptom_pkg::S_UL_WALK;
                end
            end
            ptom_pkg::S_UL_WALK:
            begin
                if ((cur_reg == tail_reg) || (slot_rdata_reg.nxt == hnd_reg))
                begin
                    state_next = ptom_pkg::S_UL_DONE;
                end
            end
            ptom_pkg::S_UL_DONE:
            begin
                state_next = ptom_pkg::S_SETTLE;
                ret_next   = (mode_reg == ptom_pkg::MODE_MODIFY) ?
                             ptom_pkg::S_M_BEST : ptom_pkg::S_O_BEST;
            end
            ptom_pkg::S_SETTLE:
            begin
                state_next = ret_reg;
            end
            ptom_pkg::S_M_BEST:
            begin
                if ((rem_reg == '0) || (tcnt_reg == ptom_pkg::MAX_TRADES)
                    || (opp_bp == '0) || !crosses)
                begin
                    state_next = ptom_pkg::S_M_END;
                end
                else
                begin
                    state_next = ptom_pkg::S_M_LEV;
                end
            end
            ptom_pkg::S_M_LEV:
            begin
                state_next = ptom_pkg::S_M_SLOT;
            end
            ptom_pkg::S_M_SLOT:
            begin
                state_next = ptom_pkg::S_SETTLE;
                ret_next   = ptom_pkg::S_M_BEST;
            end
            ptom_pkg::S_M_END:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ptom_pkg::S_SETTLE;
                    ret_next   = ptom_pkg::S_O_BEST;
                end
                else
                begin
                    state_next = ptom_pkg::S_A_LEV;
                end
            end
            ptom_pkg::S_A_LEV:
            begin
                if (nz_reg[lv_reg])
                begin
                    state_next = ptom_pkg::S_A_TAIL;
                end
                else
                begin
                    state_next = ptom_pkg::S_SETTLE;
                    ret_next   = ptom_pkg::S_O_BEST;
                end
            end
            ptom_pkg::S_A_TAIL:
            begin
                state_next = ptom_pkg::S_SETTLE;
                ret_next   = ptom_pkg::S_O_BEST;
            end
            ptom_pkg::S_O_BEST:
            begin
                state_next = ptom_pkg::S_O_RD;
            end
            ptom_pkg::S_O_RD:
            begin
                state_next = (kidx_reg < tcnt_reg) ? ptom_pkg::S_O_LOAD : ptom_pkg::S_O_HOLD;
            end
            ptom_pkg::S_O_LOAD:
            begin
                state_next = ptom_pkg::S_O_HOLD;
            end
            ptom_pkg::S_O_HOLD:
            begin
                if (m_axis_tready)
                begin
                    state_next = olast_reg ? ptom_pkg::S_IDLE : ptom_pkg::S_O_RD;
                end
            end
            default:
            begin
                state_next = ptom_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        side_next   = side_reg;
        price_next  = price_reg;
        qty_next    = qty_reg;
        hnd_next    = hnd_reg;
        s_next      = s_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        tcnt_next   = tcnt_reg;
        kidx_next   = kidx_reg;
        close_next  = close_reg;
        hout_next   = hout_reg;
        bp_next     = bp_reg;
        lv_next     = lv_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cur_next    = cur_reg;
        hnext_next  = hnext_reg;
        bb_next     = bb_reg;
        ba_next     = ba_reg;
        ostat_next  = ostat_reg;
        ohand_next  = ohand_reg;
        orh_next    = orh_reg;
        otp_next    = otp_reg;
        otq_next    = otq_reg;
        olast_next  = olast_reg;
        slot_raddr  = cur_reg;
        slot_we     = 1'b0;
        slot_waddr  = cur_reg;
        slot_wdata  = slot_rdata_reg;
        level_raddr = lv_reg;
        level_we    = 1'b0;
        level_wdata = level_rdata_reg;
        tbuf_we     = 1'b0;
        tbuf_wdata  = '{rh: cur_reg, price: bp_reg, qty: tq};
        used_we     = 1'b0;
        used_waddr  = s_reg;
        used_wval   = 1'b0;
        nz_we       = 1'b0;
        nz_wval     = 1'b0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            ptom_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                mode_next  = ptom_pkg::mode_t'(s_axis_tuser);
                side_next  = s_axis_tdata[0];
                price_next = s_axis_tdata[8:1];
                qty_next   = s_axis_tdata[24:9];
                hnd_next   = s_axis_tdata[30:25];
                tcnt_next  = '0;
            end
            ptom_pkg::S_DISPATCH:
            begin
                slot_raddr = hnd_reg;
                hout_next  = '0;
                close_next = ptom_pkg::ST_INVALID;
                if ((mode_reg == ptom_pkg::MODE_SUBMIT) && vals_ok)
                begin
                    close_next = ptom_pkg::ST_FULL;
                    s_next     = scan.free_idx;
                    rem_next   = qty_reg;
                    if (scan.free_found)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ptom_pkg::S_HREAD:
            begin
                hout_next  = hnd_reg;
                close_next = (mode_reg == ptom_pkg::MODE_MODIFY) ?
                             ptom_pkg::ST_MODIFY_FAIL : ptom_pkg::ST_CANCEL_FAIL;
                hnext_next = slot_rdata_reg.nxt;
                side_next  = slot_rdata_reg.side;
                lv_next    = {slot_rdata_reg.side, slot_rdata_reg.price};
                level_raddr = {slot_rdata_reg.side, slot_rdata_reg.price};
            end
            ptom_pkg::S_UL_LEV:
            begin
                head_next  = level_rdata_reg.head;
                tail_next  = level_rdata_reg.tail;
                cur_next   = level_rdata_reg.head;
                slot_raddr = level_rdata_reg.head;
                if (nz_reg[lv_reg] && (level_rdata_reg.head == hnd_reg))
                begin
                    if (level_rdata_reg.tail == hnd_reg)
                    begin
                        nz_we = 1'b1;
                    end
                    else
                    begin
                        level_we    = 1'b1;
                        level_wdata = '{head: hnext_reg, tail: level_rdata_reg.tail};
                    end
                end
            end
            ptom_pkg::S_UL_WALK:
            begin
                cur_next   = slot_rdata_reg.nxt;
                slot_raddr = slot_rdata_reg.nxt;
                if ((cur_reg != tail_reg) && (slot_rdata_reg.nxt == hnd_reg))
                begin
                    slot_we        = 1'b1;
                    slot_waddr     = cur_reg;
                    slot_wdata.nxt = hnext_reg;
                    if (tail_reg == hnd_reg)
                    begin
                        level_we    = 1'b1;
                        level_wdata = '{head: head_reg, tail: cur_reg};
                    end
                end
            end
            ptom_pkg::S_UL_DONE:
            begin
                used_we    = 1'b1;
                used_waddr = hnd_reg;
                close_next = ptom_pkg::ST_CANCELLED;
                hout_next  = hnd_reg;
                s_next     = hnd_reg;
                rem_next   = qty_reg;
            end
            ptom_pkg::S_SETTLE:
            begin
            end
            ptom_pkg::S_M_BEST:
            begin
                bp_next     = opp_bp;
                lv_next     = {~side_reg, opp_bp};
                level_raddr = {~side_reg, opp_bp};
            end
            ptom_pkg::S_M_LEV:
            begin
                tail_next  = level_rdata_reg.tail;
                cur_next   = level_rdata_reg.head;
                slot_raddr = level_rdata_reg.head;
            end
            ptom_pkg::S_M_SLOT:
            begin
                tbuf_we   = 1'b1;
                tcnt_next = tcnt_reg + 1'b1;
                rem_next  = rem_reg - tq;
                if (new_rem == '0)
                begin
                    used_we    = 1'b1;
                    used_waddr = cur_reg;
                    if (tail_reg == cur_reg)
                    begin
                        nz_we = 1'b1;
                    end
                    else
                    begin
                        level_we    = 1'b1;
                        level_wdata = '{head: slot_rdata_reg.nxt, tail: tail_reg};
                    end
                end
                else
                begin
                    slot_we            = 1'b1;
                    slot_wdata.rem     = new_rem;
                    slot_wdata.touched = 1'b1;
                end
            end
            ptom_pkg::S_M_END:
            begin
                hout_next   = s_reg;
                close_next  = (rem_reg == '0) ? ptom_pkg::ST_FILLED : ptom_pkg::ST_RESTED;
                lv_next     = {side_reg, price_reg};
                level_raddr = {side_reg, price_reg};
                if (rem_reg != '0)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = s_reg;
                    slot_wdata = '{side: side_reg, price: price_reg, rem: rem_reg,
                                   touched: (rem_reg != qty_reg), nxt: '0};
                    used_we    = 1'b1;
                    used_wval  = 1'b1;
                end
            end
            ptom_pkg::S_A_LEV:
            begin
                head_next  = level_rdata_reg.head;
                tail_next  = level_rdata_reg.tail;
                slot_raddr = level_rdata_reg.tail;
                if (!nz_reg[lv_reg])
                begin
                    nz_we       = 1'b1;
                    nz_wval     = 1'b1;
                    level_we    = 1'b1;
                    level_wdata = '{head: s_reg, tail: s_reg};
                end
            end
            ptom_pkg::S_A_TAIL:
            begin
                slot_we        = 1'b1;
                slot_waddr     = tail_reg;
                slot_wdata.nxt = s_reg;
                level_we       = 1'b1;
                level_wdata    = '{head: head_reg, tail: s_reg};
            end
            ptom_pkg::S_O_BEST:
            begin
                bb_next   = scan.bid;
                ba_next   = scan.ask;
                kidx_next = '0;
            end
            ptom_pkg::S_O_RD:
            begin
                ostat_next = close_reg;
                ohand_next = hout_reg;
                orh_next   = '0;
                otp_next   = '0;
                otq_next   = '0;
                olast_next = 1'b1;
            end
            ptom_pkg::S_O_LOAD:
            begin
                ostat_next = ptom_pkg::ST_TRADE;
                ohand_next = s_reg;
                orh_next   = tbuf_rdata_reg.rh;
                otp_next   = tbuf_rdata_reg.price;
                otq_next   = tbuf_rdata_reg.qty;
                olast_next = 1'b0;
            end
            ptom_pkg::S_O_HOLD:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    kidx_next = kidx_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptom_pkg::S_IDLE;
            ret_reg   <= ptom_pkg::S_IDLE;
            cnt_reg   <= '0;
            tcnt_reg  <= '0;
            kidx_reg  <= '0;
            olast_reg <= 1'b0;
            used_reg  <= '0;
            nz_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            tcnt_reg  <= tcnt_next;
            kidx_reg  <= kidx_next;
            olast_reg <= olast_next;
            if (used_we)
            begin
                used_reg[used_waddr] <= used_wval;
            end
            if (nz_we)
            begin
                nz_reg[lv_reg] <= nz_wval;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        side_reg  <= side_next;
        price_reg <= price_next;
        qty_reg   <= qty_next;
        hnd_reg   <= hnd_next;
        s_reg     <= s_next;
        rem_reg   <= rem_next;
        close_reg <= close_next;
        hout_reg  <= hout_next;
        bp_reg    <= bp_next;
        lv_reg    <= lv_next;
        head_reg  <= head_next;
        tail_reg  <= tail_next;
        cur_reg   <= cur_next;
        hnext_reg <= hnext_next;
        bb_reg    <= bb_next;
        ba_reg    <= ba_next;
        ostat_reg <= ostat_next;
        ohand_reg <= ohand_next;
        orh_reg   <= orh_next;
        otp_reg   <= otp_next;
        otq_reg   <= otq_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (level_we)
        begin
            level_mem[lv_reg] <= level_wdata;
        end
        level_rdata_reg <= level_mem[level_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tbuf_we)
        begin
            tbuf_mem[tcnt_reg] <= tbuf_wdata;
        end
        tbuf_rdata_reg <= tbuf_mem[kidx_reg];
    end

    assign m_axis_tdata = {4'b0000, ba_reg, bb_reg, otq_reg, otp_reg, orh_reg,
                           cnt_reg, ohand_reg};
    assign m_axis_tuser = ostat_reg;
    assign m_axis_tlast = olast_reg;

`ifndef ASSERT_OFF
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("Input taken while a result word is pending.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("Second command accepted before the first finished.");

    a_nonlast_is_trade: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == ptom_pkg::ST_TRADE))
        else $error("Closing status sent without tlast.");

    a_trade_qty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ptom_pkg::ST_TRADE)) |-> (otq_reg != '0))
        else $error("Trade word with zero quantity.");
`endif

endmodule

// ===== sim/price_time_order_matcher_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for price_time_order_matcher_core: drives order commands
// with random gaps and checks every result word against an in-bench order book.
// Depends on ptom_pkg and the core RTL.
module price_time_order_matcher_core_test;

    typedef struct {
        ptom_pkg::status_t            st;
        logic [ptom_pkg::SLOT_W-1:0]  h;
        logic [ptom_pkg::SEQ_W-1:0]   seq;
        logic [ptom_pkg::SLOT_W-1:0]  rh;
        logic [ptom_pkg::PRICE_W-1:0] tp;
        logic [ptom_pkg::QTY_W-1:0]   tq;
        logic [ptom_pkg::PRICE_W-1:0] bid;
        logic [ptom_pkg::PRICE_W-1:0] ask;
        logic                         last;
    } book_word_t;

    class book_scoreboard;
        bit                           used[ptom_pkg::SLOTS];
        bit                           sd[ptom_pkg::SLOTS];
        logic [ptom_pkg::PRICE_W-1:0] pr[ptom_pkg::SLOTS];
        logic [ptom_pkg::QTY_W-1:0]   rem[ptom_pkg::SLOTS];
        bit                           touched[ptom_pkg::SLOTS];
        logic [ptom_pkg::SLOT_W-1:0]  nxt[ptom_pkg::SLOTS];
        bit                           lvl_on[2*ptom_pkg::LEVELS];
        logic [ptom_pkg::SLOT_W-1:0]  head[2*ptom_pkg::LEVELS];
        logic [ptom_pkg::SLOT_W-1:0]  tail[2*ptom_pkg::LEVELS];
        bit [ptom_pkg::SEQ_W-1:0]     accepted;
        book_word_t                   step_words[$];
        book_word_t                   expected_words[$];
        int                           errors;
        int                           words_seen;
        int                           trades_seen;
        int                           full_seen;

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int best_of(bit s);
            if (s == 1'b0)
            begin
                for (int p = ptom_pkg::LEVELS - 1; p >= 1; p--)
                    if (lvl_on[p]) return p;
            end
            else
            begin
                for (int p = 1; p < ptom_pkg::LEVELS; p++)
                    if (lvl_on[ptom_pkg::LEVELS + p]) return p;
            end
            return 0;
        endfunction

        function void add_word(ptom_pkg::status_t st, int h, int rh, int tp, int tq);
            book_word_t w;
            w.st = st;
            w.h = ptom_pkg::SLOT_W'(h);
            w.rh = ptom_pkg::SLOT_W'(rh);
            w.tp = ptom_pkg::PRICE_W'(tp);
            w.tq = ptom_pkg::QTY_W'(tq);
            w.seq = '0;
            w.bid = '0;
            w.ask = '0;
            w.last = 1'b0;
            step_words.push_back(w);
        endfunction

        function void join_level(int s);
            int lv;
            lv = int'(sd[s]) * ptom_pkg::LEVELS + int'(pr[s]);
            if (lvl_on[lv])
            begin
                nxt[tail[lv]] = ptom_pkg::SLOT_W'(s);
                tail[lv] = ptom_pkg::SLOT_W'(s);
            end
            else
            begin
                lvl_on[lv] = 1'b1;
                head[lv] = ptom_pkg::SLOT_W'(s);
                tail[lv] = ptom_pkg::SLOT_W'(s);
            end
        endfunction

        function void leave_level(int s);
            int lv;
            int cur;
            int nx;
            lv = int'(sd[s]) * ptom_pkg::LEVELS + int'(pr[s]);
            if (!lvl_on[lv]) return;
            if (int'(head[lv]) == s)
            begin
                if (int'(tail[lv]) == s) lvl_on[lv] = 1'b0;
                else head[lv] = nxt[s];
                return;
            end
            cur = int'(head[lv]);
            for (int i = 0; i < ptom_pkg::SLOTS; i++)
            begin
                nx = int'(nxt[cur]);
                if (cur == int'(tail[lv])) return;
                if (nx == s)
                begin
                    nxt[cur] = nxt[s];
                    if (int'(tail[lv]) == s) tail[lv] = ptom_pkg::SLOT_W'(cur);
                    return;
                end
                cur = nx;
            end
        endfunction

        function void cross_book(int s, bit side, int price, int qty);
            int left;
            int guard;
            int bp;
            int lv;
            int r;
            int tq;
            left = qty;
            guard = 0;
            while (left > 0 && guard < ptom_pkg::SLOTS - 1)
            begin
                bp = best_of(!side);
                if (bp == 0) break;
                if (side == 1'b0 ? (bp > price) : (bp < price)) break;
                lv = int'(!side) * ptom_pkg::LEVELS + bp;
                r = int'(head[lv]);
                tq = (left < int'(rem[r])) ? left : int'(rem[r]);
                left -= tq;
                rem[r] = rem[r] - ptom_pkg::QTY_W'(tq);
                add_word(ptom_pkg::ST_TRADE, s, r, bp, tq);
                guard++;
                if (rem[r] == 0)
                begin
                    if (int'(tail[lv]) == r) lvl_on[lv] = 1'b0;
                    else head[lv] = nxt[r];
                    used[r] = 1'b0;
                end
                else
                begin
                    touched[r] = 1'b1;
                end
            end
            if (left == 0)
            begin
                used[s] = 1'b0;
                add_word(ptom_pkg::ST_FILLED, s, 0, 0, 0);
                return;
            end
            used[s] = 1'b1;
            sd[s] = side;
            pr[s] = ptom_pkg::PRICE_W'(price);
            rem[s] = ptom_pkg::QTY_W'(left);
            touched[s] = (left != qty);
            join_level(s);
            add_word(ptom_pkg::ST_RESTED, s, 0, 0, 0);
        endfunction

        function void note_command(ptom_pkg::mode_t mode, bit side, int price, int qty,
                                   int h);
            bit ok_vals;
            int s;
            int bb;
            int ba;
            ok_vals = (price != 0 && qty != 0);
            step_words.delete();
            unique case (mode)
                ptom_pkg::MODE_SUBMIT:
                begin
                    if (!ok_vals)
                    begin
                        add_word(ptom_pkg::ST_INVALID, 0, 0, 0, 0);
                    end
                    else
                    begin
                        for (s = 0; s < ptom_pkg::SLOTS; s++)
                            if (!used[s]) break;
                        if (s >= ptom_pkg::SLOTS)
                        begin
                            add_word(ptom_pkg::ST_FULL, 0, 0, 0, 0);
                        end
                        else
                        begin
                            accepted = accepted + 1'b1;
                            cross_book(s, side, price, qty);
                        end
                    end
                end
                ptom_pkg::MODE_CANCEL:
                begin
                    if (used[h])
                    begin
                        leave_level(h);
                        used[h] = 1'b0;
                        add_word(ptom_pkg::ST_CANCELLED, h, 0, 0, 0);
                    end
                    else
                    begin
                        add_word(ptom_pkg::ST_CANCEL_FAIL, h, 0, 0, 0);
                    end
                end
                ptom_pkg::MODE_MODIFY:
                begin
                    if (used[h] && !touched[h] && ok_vals)
                    begin
                        leave_level(h);
                        used[h] = 1'b0;
                        cross_book(h, sd[h], price, qty);
                    end
                    else
                    begin
                        add_word(ptom_pkg::ST_MODIFY_FAIL, h, 0, 0, 0);
                    end
                end
                default: add_word(ptom_pkg::ST_INVALID, 0, 0, 0, 0);
            endcase
            bb = best_of(1'b0);
            ba = best_of(1'b1);
            foreach (step_words[k])
            begin
                step_words[k].seq = accepted;
                step_words[k].bid = ptom_pkg::PRICE_W'(bb);
                step_words[k].ask = ptom_pkg::PRICE_W'(ba);
                step_words[k].last = (k == step_words.size() - 1);
                expected_words.push_back(step_words[k]);
            end
        endfunction

        task check_word(logic [87:0] d, logic [2:0] u, logic l);
            book_word_t e;
            words_seen++;
            if (expected_words.size() == 0)
            begin
                report($sformatf("unexpected word status %0d", u));
                return;
            end
            e = expected_words.pop_front();
            if (e.st == ptom_pkg::ST_TRADE) trades_seen++;
            if (e.st == ptom_pkg::ST_FULL) full_seen++;
            if (u !== e.st) report($sformatf("status %0d, want %0d", u, e.st));
            if (d[5:0] !== e.h) report($sformatf("handle %0d, want %0d", d[5:0], e.h));
            if (d[37:6] !== e.seq)
                report($sformatf("sequence %0d, want %0d", d[37:6], e.seq));
            if (d[43:38] !== e.rh)
                report($sformatf("resting %0d, want %0d", d[43:38], e.rh));
            if (d[51:44] !== e.tp)
                report($sformatf("trade price %0d, want %0d", d[51:44], e.tp));
            if (d[67:52] !== e.tq)
                report($sformatf("trade qty %0d, want %0d", d[67:52], e.tq));
            if (d[75:68] !== e.bid)
                report($sformatf("best bid %0d, want %0d", d[75:68], e.bid));
            if (d[83:76] !== e.ask)
                report($sformatf("best ask %0d, want %0d", d[83:76], e.ask));
            if (d[87:84] !== 4'd0) report($sformatf("pad bits %0h", d[87:84]));
            if (l !== e.last) report($sformatf("last %0b, want %0b", l, e.last));
        endtask

        function int pick_handle();
            int live[$];
            for (int i = 0; i < ptom_pkg::SLOTS; i++)
                if (used[i]) live.push_back(i);
            if (live.size() == 0 || $urandom_range(9) < 2)
                return $urandom_range(ptom_pkg::SLOTS - 1);
            return live[$urandom_range(live.size() - 1)];
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    book_scoreboard book = new();
    bit  calm = 1'b0;
    int  quiet_cycles = 0;
    int  commands_sent = 0;

    localparam int QUIET_LIMIT = 20000;

    price_time_order_matcher_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n) m_tready <= calm || ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                book.note_command(ptom_pkg::mode_t'(s_tuser), s_tdata[0], int'(s_tdata[8:1]),
                                  int'(s_tdata[24:9]), int'(s_tdata[30:25]));
            if (m_tvalid && m_tready) book.check_word(m_tdata, m_tuser, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("price_time_order_matcher_core_test: errors");
        $finish;
    end

    task automatic send(ptom_pkg::mode_t mode, bit side, int price, int qty, int h);
        while (!calm && $urandom_range(99) < 35)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {1'b0, h[5:0], qty[15:0], price[7:0], side};
        do @(posedge clk); while (!s_tready);
        commands_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (book.expected_words.size() != 0) @(posedge clk);
    endtask

    task automatic random_command();
        int r;
        int price;
        int qty;
        r = $urandom_range(99);
        price = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(140, 100);
        qty = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(300, 1);
        if ($urandom_range(29) == 0) qty = 0;
        if ($urandom_range(29) == 0) price = 0;
        if (r < 55)
            send(ptom_pkg::MODE_SUBMIT, 1'($urandom_range(1)), price, qty, $urandom_range(63));
        else if (r < 72)
            send(ptom_pkg::MODE_CANCEL, 1'($urandom_range(1)), price, qty, book.pick_handle());
        else if (r < 92)
            send(ptom_pkg::MODE_MODIFY, 1'($urandom_range(1)), price, qty, book.pick_handle());
        else
            send(ptom_pkg::mode_t'($urandom_range(3)), 1'($urandom_range(1)),
                 $urandom_range(255), $urandom_range(65535), $urandom_range(63));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(ptom_pkg::MODE_SUBMIT, 0, 0, 5, 0);
        send(ptom_pkg::MODE_SUBMIT, 1, 10, 0, 0);
        send(ptom_pkg::MODE_BAD, 0, 10, 5, 0);
        send(ptom_pkg::MODE_CANCEL, 0, 0, 0, 63);
        send(ptom_pkg::MODE_MODIFY, 0, 10, 5, 5);
        send(ptom_pkg::MODE_SUBMIT, 0, 100, 10, 0);
        send(ptom_pkg::MODE_SUBMIT, 0, 100, 20, 0);
        send(ptom_pkg::MODE_SUBMIT, 1, 101, 5, 0);
        send(ptom_pkg::MODE_MODIFY, 0, 0, 15, 2);
        send(ptom_pkg::MODE_MODIFY, 0, 99, 0, 2);
        send(ptom_pkg::MODE_MODIFY, 0, 99, 15, 2);
        send(ptom_pkg::MODE_MODIFY, 0, 90, 5, 1);
        send(ptom_pkg::MODE_CANCEL, 0, 0, 0, 1);
        send(ptom_pkg::MODE_CANCEL, 0, 0, 0, 1);
        send(ptom_pkg::MODE_SUBMIT, 0, 255, 65535, 0);
        send(ptom_pkg::MODE_SUBMIT, 1, 1, 65535, 0);
        send(ptom_pkg::MODE_SUBMIT, 1, 1, 1, 63);
        send(ptom_pkg::MODE_SUBMIT, 0, 1, 7, 0);
        send(ptom_pkg::MODE_MODIFY, 1, 255, 3, 0);
        send(ptom_pkg::MODE_SUBMIT, 0, 255, 2, 0);
        drain();

        repeat (120) random_command();
        drain();

        calm = 1'b1;
        repeat (50) random_command();
        calm = 1'b0;

        for (int i = 0; i < ptom_pkg::SLOTS; i++)
            if (book.used[i]) send(ptom_pkg::MODE_CANCEL, 0, 0, 0, i);
        repeat (70)
            send(ptom_pkg::MODE_SUBMIT, 0, $urandom_range(120, 1), $urandom_range(1000, 1), 0);
        repeat (3) send(ptom_pkg::MODE_SUBMIT, 1, 1, 65535, 0);
        repeat (70) random_command();

        drain();
        repeat (50) @(posedge clk);
        $display("Sent %0d commands; checked %0d result words, %0d trades, %0d book-full rejects.",
                 commands_sent, book.words_seen, book.trades_seen, book.full_seen);
        if (book.errors == 0 && book.expected_words.size() == 0)
            $display("price_time_order_matcher_core_test: clean");
        else
            $display("price_time_order_matcher_core_test: errors");
        $finish;
    end
endmodule
